// ===== rtl/core/stepper_pwm_frequency_ramp_assert.svh =====
// assertion macros shared by the stepper ramp rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef STEPPER_PWM_FREQUENCY_RAMP_ASSERT_SVH
`define STEPPER_PWM_FREQUENCY_RAMP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/spfr_pkg.sv =====
// shared types and constants of the stepper frequency ramp
// used by the divider, datapath, controller and top level
`default_nettype none

package spfr_pkg;

   localparam int CLK_W   = 32;
   localparam int FREQ_W  = 24;
   localparam int PRE_W   = 16;
   localparam int DIV_W   = 41;
   localparam int Q_W     = 32;
   localparam int CNT_W   = 5;
   localparam int CSR_W   = 2;
   localparam int REQ_W   = 8;
   localparam int RSP_W   = 80;

   localparam logic [PRE_W-1:0]  PRESCALE_MAX   = 16'hFFFF;
   localparam logic [PRE_W-1:0]  PERIOD_MAX     = 16'hFFFF;
   localparam logic [Q_W-1:0]    PERIOD_LIMIT_Q = 32'h0001_0000;
   localparam logic [CLK_W-1:0]  TIMER_CLOCK_RST = 32'd168000000;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 24'd30000;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 24'd200000;
   localparam logic [FREQ_W-1:0] RAMP_STEP_RST  = 24'd10000;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_STOP   = 2'd1,
      OP_RAMP   = 2'd2,
      OP_SETDIR = 2'd3
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      REG_TIMER_CLOCK = 2'd0,
      REG_MIN_FREQ    = 2'd1,
      REG_MAX_FREQ    = 2'd2,
      REG_RAMP_STEP   = 2'd3
   } reg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic load;
      logic div_start;
      logic div_period;
      logic set_prescale;
      logic mul;
      logic set_period;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   ramp_ok;
      logic   target_zero;
      logic   div_done;
   } status_type;

   // result word, last member in the lowest bits
   typedef struct packed {
      logic [2:0]        pad;
      logic              divider_error;
      logic              motor_on;
      logic              direction_level;
      logic              enable_level;
      logic              pwm_running;
      logic [FREQ_W-1:0] step_frequency;
      logic [PRE_W-1:0]  compare_out;
      logic [PRE_W-1:0]  period_out;
      logic [PRE_W-1:0]  prescale_out;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/spfr_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on spfr_pkg and the assertion macro header
`default_nettype none
`include "stepper_pwm_frequency_ramp_assert.svh"

module spfr_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [spfr_pkg::Q_W-1:0]   dividend,
   input  wire logic [spfr_pkg::DIV_W-1:0] divisor,
   output logic                        done,
   output logic [spfr_pkg::Q_W-1:0]        quotient
);
   import spfr_pkg::*;

   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] den_ff;
   logic [Q_W-1:0]   quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[Q_W-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_IMPLIES(a_no_restart_while_busy, clock, reset, start, !busy_ff)

endmodule

`default_nettype wire

// ===== rtl/core/spfr_dp.sv =====
// datapath: config registers, motor state, timer settings and result register
// depends on spfr_pkg, spfr_div and the assertion macro header
`default_nettype none
`include "stepper_pwm_frequency_ramp_assert.svh"

module spfr_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [spfr_pkg::REQ_W-1:0] req_tdata,
   input  wire logic [1:0]              req_tuser,
   input  wire logic                    csr_valid,
   input  wire logic [spfr_pkg::CSR_W-1:0] csr_index,
   input  wire logic [spfr_pkg::CLK_W-1:0] csr_data,
   input  wire spfr_pkg::cmd_type       cmd,
   output spfr_pkg::status_type         status,
   output spfr_pkg::result_type         result
);
   import spfr_pkg::*;

   // configuration
   logic [CLK_W-1:0]  timer_clock_ff;
   logic [FREQ_W-1:0] min_freq_ff;
   logic [FREQ_W-1:0] max_freq_ff;
   logic [FREQ_W-1:0] ramp_step_ff;

   // captured command
   op_type            op_ff;
   logic              dir_req_ff;

   // motor state
   logic [PRE_W-1:0]  prescale_ff;
   logic [PRE_W-1:0]  period_ff;
   logic [PRE_W-1:0]  compare_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic              pwm_on_ff;
   logic              enable_pin_ff;
   logic              direction_pin_ff;
   logic              running_ff;
   logic              error_ff;

   logic [FREQ_W-1:0] target_ff;
   logic [DIV_W-1:0]  prod_ff;
   result_type        result_ff;

   logic [FREQ_W:0]   ramp_sum;
   logic [FREQ_W-1:0] ramp_next;
   logic              ramp_ok;
   logic [DIV_W-1:0]  need_den;
   logic [PRE_W:0]    pre_inc;
   logic [DIV_W-1:0]  prod_in;
   logic [DIV_W-1:0]  div_den;
   logic              div_done;
   logic [Q_W-1:0]    div_q;
   logic [Q_W-1:0]    q_less_one;

   assign ramp_ok   = freq_ff < max_freq_ff;
   assign ramp_sum  = {1'b0, freq_ff} + {1'b0, ramp_step_ff};
   assign ramp_next = (ramp_sum >= {1'b0, max_freq_ff}) ? max_freq_ff
                                                        : ramp_sum[FREQ_W-1:0];

   // freq * 65537 as a shift and add
   assign need_den = DIV_W'({target_ff, 16'h0000}) + DIV_W'(target_ff);
   assign pre_inc  = {1'b0, prescale_ff} + 1'b1;
   assign prod_in  = DIV_W'(target_ff) * DIV_W'(pre_inc);
   assign div_den  = cmd.div_period ? prod_ff : need_den;
   assign q_less_one = div_q - 1'b1;

   spfr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (timer_clock_ff),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff <= TIMER_CLOCK_RST;
         min_freq_ff    <= MIN_FREQ_RST;
         max_freq_ff    <= MAX_FREQ_RST;
         ramp_step_ff   <= RAMP_STEP_RST;
      end else if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_TIMER_CLOCK: timer_clock_ff <= csr_data;
            REG_MIN_FREQ:    min_freq_ff    <= csr_data[FREQ_W-1:0];
            REG_MAX_FREQ:    max_freq_ff    <= csr_data[FREQ_W-1:0];
            REG_RAMP_STEP:   ramp_step_ff   <= csr_data[FREQ_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_tuser);
         dir_req_ff <= req_tdata[0];
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.publish) begin
         result_ff.pad             <= '0;
         result_ff.divider_error   <= error_ff;
         result_ff.motor_on        <= running_ff;
         result_ff.direction_level <= direction_pin_ff;
         result_ff.enable_level    <= enable_pin_ff;
         result_ff.pwm_running     <= pwm_on_ff;
         result_ff.step_frequency  <= freq_ff;
         result_ff.compare_out     <= compare_ff;
         result_ff.period_out      <= period_ff;
         result_ff.prescale_out    <= prescale_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff      <= '0;
         period_ff        <= '0;
         compare_ff       <= '0;
         freq_ff          <= '0;
         pwm_on_ff        <= 1'b0;
         enable_pin_ff    <= 1'b1;
         direction_pin_ff <= 1'b0;
         running_ff       <= 1'b0;
         error_ff         <= 1'b0;
         target_ff        <= '0;
      end else begin
         if (cmd.decode) begin
            unique case (op_ff)
               OP_START: begin
                  target_ff     <= min_freq_ff;
                  pwm_on_ff     <= 1'b1;
                  enable_pin_ff <= 1'b0;
                  running_ff    <= 1'b1;
               end
               OP_STOP: begin
                  target_ff     <= min_freq_ff;
                  pwm_on_ff     <= 1'b0;
                  enable_pin_ff <= 1'b1;
                  running_ff    <= 1'b0;
               end
               OP_RAMP: begin
                  if (ramp_ok) begin
                     target_ff <= ramp_next;
                     pwm_on_ff <= 1'b1;
                  end
               end
               OP_SETDIR: begin
                  direction_pin_ff <= dir_req_ff;
               end
            endcase
         end
         if (cmd.load) begin
            freq_ff <= target_ff;
            if (target_ff == '0) begin
               // zero frequency: quotient counts as infinitely large
               prescale_ff <= PRESCALE_MAX;
               period_ff   <= PERIOD_MAX;
               compare_ff  <= PERIOD_MAX >> 1;
               error_ff    <= 1'b1;
            end else begin
               error_ff <= 1'b0;
            end
         end
         if (cmd.set_prescale && (div_q > Q_W'(prescale_ff))) begin
            prescale_ff <= (div_q > Q_W'(PRESCALE_MAX)) ? PRESCALE_MAX : div_q[PRE_W-1:0];
         end
         if (cmd.set_period) begin
            priority if (div_q == '0) begin
               // frequency too high for the timer
               period_ff  <= '0;
               compare_ff <= '0;
               error_ff   <= 1'b1;
            end else if (div_q > PERIOD_LIMIT_Q) begin
               period_ff  <= PERIOD_MAX;
               compare_ff <= PERIOD_MAX >> 1;
               error_ff   <= 1'b1;
            end else begin
               period_ff  <= q_less_one[PRE_W-1:0];
               compare_ff <= {1'b0, q_less_one[PRE_W-1:1]};
            end
         end
      end
   end

   assign status.op          = op_ff;
   assign status.ramp_ok     = ramp_ok;
   assign status.target_zero = (target_ff == '0);
   assign status.div_done    = div_done;
   assign result             = result_ff;

   `ASSERT_ALWAYS(a_compare_is_half_period, clock, reset, compare_ff == (period_ff >> 1))

endmodule

`default_nettype wire

// ===== rtl/core/spfr_ctrl.sv =====
// sequencer for one command: decode, up to two divisions, result handoff
// depends on spfr_pkg and the assertion macro header
`default_nettype none
`include "stepper_pwm_frequency_ramp_assert.svh"

module spfr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire spfr_pkg::status_type status,
   output spfr_pkg::cmd_type         cmd
);
   import spfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_DIV_NEED,
      ST_MULT,
      ST_START_PER,
      ST_DIV_PER,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.op == OP_SETDIR || (status.op == OP_RAMP && !status.ramp_ok)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.target_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_NEED;
            end
         end
         ST_DIV_NEED: begin
            if (status.div_done) begin
               cmd.set_prescale = 1'b1;
               state_in         = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mul  = 1'b1;
            state_in = ST_START_PER;
         end
         ST_START_PER: begin
            cmd.div_start  = 1'b1;
            cmd.div_period = 1'b1;
            state_in       = ST_DIV_PER;
         end
         ST_DIV_PER: begin
            if (status.div_done) begin
               cmd.set_period = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_NEXT(a_one_command_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_div_done_when_waiting, clock, reset, status.div_done,
                   state_ff == ST_DIV_NEED || state_ff == ST_DIV_PER)
   `ASSERT_NEXT(a_period_then_finish, clock, reset,
                state_ff == ST_DIV_PER && status.div_done, state_ff == ST_FINISH)

endmodule

`default_nettype wire

// ===== rtl/core/stepper_pwm_frequency_ramp.sv =====
// Stepper step-rate generator with a frequency ramp.
// req channel: one command per transfer, tuser carries the command code
//   (start, stop, ramp up, set direction), tdata bit 0 the direction level.
// rsp channel: exactly one result transfer per command, holding the full
//   motor and timer state after that command.
// csr channel: always ready; writes timer clock, min/max frequency and ramp
//   step. Write only while no command is in flight.
// Sequence: a command that loads a frequency runs decode, load and the two
//   32-step restoring divisions (prescaler search, then a multiply and the
//   period). Set direction or a ramp at the ceiling skip from decode, a zero
//   frequency load from load, straight to the result handoff.
// Flow: one command in flight; req_tready rises again once the result sits in
//   the output register.
// Stalls: a held result stays stable; a second finished result waits in the
//   sequencer until the output register frees up, and no command is taken.
// Reset: driver disabled (enable level high), all timer values, frequency and
//   flags zero, config back to its defaults.
`default_nettype none

module stepper_pwm_frequency_ramp (
   input  wire logic        clock,
   input  wire logic        reset,
   // command input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] direction, [7:1] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] prescale_out, [31:16] period_out, [47:32] compare_out,
   // [71:48] step_frequency, [72] pwm_running, [73] enable_level,
   // [74] direction_level, [75] motor_on, [76] divider_error, [79:77] zero
   output logic [79:0]      rsp_tdata,
   // config writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import spfr_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;

   // config writes are always accepted
   assign csr_ready = 1'b1;

   spfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spfr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .result    (result)
   );

   // result struct is laid out to match the tdata packing
   assign rsp_tdata = RSP_W'(result);

endmodule

`default_nettype wire

// ===== test/stepper_ramp_checker.sv =====
// scoreboard for the stepper frequency ramp: watches the csr, req and rsp channels,
// keeps its own copy of the motor and timer state and checks every result transfer
// depends on spfr_pkg for the command, register and result word types
`timescale 1ns / 1ps

module stepper_ramp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import spfr_pkg::*;

   // configuration copy
   logic [CLK_W-1:0]  timer_clk;
   logic [FREQ_W-1:0] min_freq;
   logic [FREQ_W-1:0] max_freq;
   logic [FREQ_W-1:0] ramp_inc;

   // motor and timer state copy
   logic [PRE_W-1:0]  prescale_now;
   logic [PRE_W-1:0]  period_now;
   logic [PRE_W-1:0]  compare_now;
   logic [FREQ_W-1:0] freq_now;
   logic              pwm_now;
   logic              enable_now;
   logic              dir_now;
   logic              motor_now;
   logic              error_now;

   result_type expected_states[$];
   result_type want;
   result_type got;
   int         errors = 0;

   assign fail_count = errors;

   // convert a new step frequency into prescaler, period and compare
   task automatic retune(input logic [FREQ_W-1:0] f);
      logic [63:0] clk64;
      logic [63:0] f64;
      logic [63:0] need;
      logic [63:0] quot;
      logic [63:0] quot_m1;
      clk64 = {32'd0, timer_clk};
      f64 = {40'd0, f};
      freq_now = f;
      error_now = 1'b0;
      if (f == '0) begin
         prescale_now = PRESCALE_MAX;
         period_now = PERIOD_MAX;
         error_now = 1'b1;
      end else begin
         need = clk64 / (f64 * 64'd65537);
         if (need > {48'd0, prescale_now})
            prescale_now = (need > 64'hFFFF) ? PRESCALE_MAX : need[PRE_W-1:0];
         quot = clk64 / (f64 * ({48'd0, prescale_now} + 64'd1));
         quot_m1 = quot - 64'd1;
         if (quot == 64'd0) begin
            period_now = '0;
            error_now = 1'b1;
         end else if (quot_m1 > 64'hFFFF) begin
            period_now = PERIOD_MAX;
            error_now = 1'b1;
         end else begin
            period_now = quot_m1[PRE_W-1:0];
         end
      end
      compare_now = period_now >> 1;
   endtask

   task automatic advance_motor(input logic [1:0] op, input logic dir, output result_type res);
      logic [31:0] next_f;
      case (op)
         OP_START: begin
            retune(min_freq);
            pwm_now = 1'b1;
            enable_now = 1'b0;
            motor_now = 1'b1;
         end
         OP_STOP: begin
            enable_now = 1'b1;
            retune(min_freq);
            pwm_now = 1'b0;
            motor_now = 1'b0;
         end
         OP_RAMP: begin
            if (freq_now < max_freq) begin
               next_f = {8'd0, freq_now} + {8'd0, ramp_inc};
               if (next_f >= {8'd0, max_freq})
                  next_f = {8'd0, max_freq};
               retune(next_f[FREQ_W-1:0]);
               pwm_now = 1'b1;
            end
         end
         default: begin
            dir_now = dir;
         end
      endcase
      res = '0;
      res.prescale_out = prescale_now;
      res.period_out = period_now;
      res.compare_out = compare_now;
      res.step_frequency = freq_now;
      res.pwm_running = pwm_now;
      res.enable_level = enable_now;
      res.direction_level = dir_now;
      res.motor_on = motor_now;
      res.divider_error = error_now;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         if (errors < 10)
            $display("%0t: %s expected %0d, got %0d", $realtime, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timer_clk = TIMER_CLOCK_RST;
         min_freq = MIN_FREQ_RST;
         max_freq = MAX_FREQ_RST;
         ramp_inc = RAMP_STEP_RST;
         prescale_now = '0;
         period_now = '0;
         compare_now = '0;
         freq_now = '0;
         pwm_now = 1'b0;
         enable_now = 1'b1;
         dir_now = 1'b0;
         motor_now = 1'b0;
         error_now = 1'b0;
         expected_states.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMER_CLOCK: timer_clk = csr_data;
               REG_MIN_FREQ:    min_freq = csr_data[FREQ_W-1:0];
               REG_MAX_FREQ:    max_freq = csr_data[FREQ_W-1:0];
               default:         ramp_inc = csr_data[FREQ_W-1:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_states.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result transfer with no command outstanding", $realtime);
               errors++;
            end else begin
               want = expected_states.pop_front();
               check_field("prescale_out", 32'(want.prescale_out), 32'(got.prescale_out));
               check_field("period_out", 32'(want.period_out), 32'(got.period_out));
               check_field("compare_out", 32'(want.compare_out), 32'(got.compare_out));
               check_field("step_frequency", 32'(want.step_frequency),
                           32'(got.step_frequency));
               check_field("pwm_running", 32'(want.pwm_running), 32'(got.pwm_running));
               check_field("enable_level", 32'(want.enable_level), 32'(got.enable_level));
               check_field("direction_level", 32'(want.direction_level),
                           32'(got.direction_level));
               check_field("motor_on", 32'(want.motor_on), 32'(got.motor_on));
               check_field("divider_error", 32'(want.divider_error),
                           32'(got.divider_error));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_motor(req_tuser, req_tdata[0], want);
            expected_states.push_back(want);
         end
         pending <= expected_states.size();
      end
   end

endmodule

// ===== test/tb_stepper_pwm_frequency_ramp.sv =====
// top of the stepper frequency ramp testbench: clock, reset, command stimulus,
// csr writes, result back-pressure and the final verdict
// depends on spfr_pkg, stepper_pwm_frequency_ramp and stepper_ramp_checker
`timescale 1ns / 1ps

module tb_stepper_pwm_frequency_ramp;
   import spfr_pkg::*;

   // generous bound on the run length for the watchdog
   localparam int unsigned CYCLE_LIMIT = 1000000;
   // cycles a frequency load needs inside the block, with margin
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [0] direction, [7:1] zero
   logic [1:0]  req_tuser = OP_START; // [1:0] cmd

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] prescale, [31:16] period, [47:32] compare, [71:48] step frequency,
   // [72] pwm running, [73] enable, [74] direction, [75] motor on, [76] divider error
   logic [79:0] rsp_tdata;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_TIMER_CLOCK;
   logic [31:0] csr_data = '0;

   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;

   // sender-side burst mode: no gaps between command transfers
   bit          tx_quiet = 1'b0;
   // receiver-side stall state
   bit          rx_quiet = 1'b0;
   int          rx_hold = 0;
   int          rx_draw;

   always #5 clock = ~clock;

   stepper_pwm_frequency_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   stepper_ramp_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // result receiver: after every transfer draw a random stall length, possibly zero,
   // now and then switch into a stretch where tready simply stays high
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 39) == 0)
            rx_quiet = !rx_quiet;
         rx_draw = rx_quiet ? 0 : $urandom_range(0, 11);
         rsp_tready <= (rx_draw == 0);
         rx_hold <= rx_draw;
      end else if (!rsp_tready) begin
         if (rx_hold <= 1)
            rsp_tready <= 1'b1;
         rx_hold <= rx_hold - 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one command transfer; returns at the accepting edge with tvalid still high
   // so a back-to-back command can follow without a bubble
   task automatic send_command(input logic [1:0] op, input logic dir);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, dir};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop tvalid and hold off until every result has been seen
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // registers only change with no command in flight
   task automatic write_config(input logic [31:0] clk_hz, input logic [23:0] lo_hz,
                               input logic [23:0] hi_hz, input logic [23:0] inc_hz);
      settle();
      write_reg(REG_TIMER_CLOCK, clk_hz);
      write_reg(REG_MIN_FREQ, {8'd0, lo_hz});
      write_reg(REG_MAX_FREQ, {8'd0, hi_hz});
      write_reg(REG_RAMP_STEP, {8'd0, inc_hz});
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed motor runs (start, a ramp of random length with the
   // odd direction change, often a stop), the rest short bursts of any command
   task automatic drive_motor_runs(input int n_items);
      int         sent;
      int         steps;
      int         burst;
      logic [1:0] op;
      sent = 0;
      while (sent < n_items) begin
         tx_quiet = ($urandom_range(0, 5) == 0);
         // hold-off until the block has drained completely
         if ($urandom_range(0, 29) == 0)
            settle();
         if ($urandom_range(0, 9) != 0) begin
            send_command(OP_START, 1'($urandom_range(0, 1)));
            steps = $urandom_range(0, 20);
            repeat (steps) begin
               if ($urandom_range(0, 5) == 0)
                  send_command(OP_SETDIR, 1'($urandom_range(0, 1)));
               else
                  send_command(OP_RAMP, 1'($urandom_range(0, 1)));
            end
            sent += steps + 1;
            if ($urandom_range(0, 1) == 1) begin
               send_command(OP_STOP, 1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               op = 2'($urandom_range(0, 3));
               send_command(op, 1'($urandom_range(0, 1)));
            end
            sent += burst;
         end
      end
   endtask

   // random settings; the timer clock ceiling grows with the level since the
   // prescaler never shrinks and a huge clock early would pin it at the top
   task automatic random_config(input int level);
      logic [31:0] clk_hz;
      logic [31:0] lo_hz;
      logic [31:0] hi_hz;
      logic [31:0] inc_hz;
      logic [31:0] span;
      if (level < 6) begin
         clk_hz = $urandom_range(1, (32'd1 << (18 + 2 * level)) - 1);
      end else begin
         clk_hz = $urandom;
         if (clk_hz == 0)
            clk_hz = 1;
      end
      lo_hz = $urandom_range(1, (32'd1 << $urandom_range(4, 24)) - 1);
      span = $urandom_range(0, (32'd1 << $urandom_range(4, 24)) - 1);
      if ($urandom_range(0, 3) == 0)
         hi_hz = $urandom_range(1, 32'hFFFFFF);
      else
         hi_hz = (lo_hz + span > 32'hFFFFFF) ? 32'hFFFFFF : lo_hz + span;
      case ($urandom_range(0, 7))
         0:       inc_hz = 0;
         1:       inc_hz = 32'hFFFFFF;
         default: inc_hz = span / $urandom_range(1, 12);
      endcase
      write_config(clk_hz, lo_hz[23:0], hi_hz[23:0], inc_hz[23:0]);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default clock, coarse ramp so the ceiling comes quickly
      write_config(32'd168000000, 24'd30000, 24'd200000, 24'd50000);
      send_command(OP_START, 1'b1);
      send_command(OP_SETDIR, 1'b1);
      send_command(OP_SETDIR, 1'b0);
      send_command(OP_RAMP, 1'b1);
      send_command(OP_RAMP, 1'b0);
      send_command(OP_RAMP, 1'b1);
      // this one clips at the maximum, the next one finds it reached
      send_command(OP_RAMP, 1'b0);
      send_command(OP_RAMP, 1'b1);
      send_command(OP_STOP, 1'b1);
      // ramp after stop reloads and restarts pwm but leaves enable alone
      send_command(OP_RAMP, 1'b0);
      send_command(OP_SETDIR, 1'b1);

      // directed: timer clock far too slow for the frequency, period pinned at zero
      write_config(32'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_command(OP_START, 1'b0);
      send_command(OP_RAMP, 1'b1);
      send_command(OP_SETDIR, 1'b0);
      send_command(OP_STOP, 1'b0);

      // random phases with a growing clock range
      for (int level = 0; level < 8; level++) begin
         random_config(level);
         drive_motor_runs(55);
      end

      // largest clock, lowest frequency: the prescaler goes all the way up
      write_config(32'hFFFFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF);
      drive_motor_runs(30);

      // zero frequency: prescaler and period saturate, error raised
      write_config(32'hFFFFFFFF, 24'd0, 24'd5000, 24'd2500);
      drive_motor_runs(20);
      write_config(32'hFFFFFFFF, 24'd0, 24'd1, 24'd0);
      drive_motor_runs(20);

      // drain, then give a stray result the chance to show up
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spfr_pkg.sv
rtl/core/spfr_div.sv
rtl/core/spfr_dp.sv
rtl/core/spfr_ctrl.sv
rtl/core/stepper_pwm_frequency_ramp.sv
test/stepper_ramp_checker.sv
test/tb_stepper_pwm_frequency_ramp.sv
